// File: hw/rtl/ebl_pkg.sv
// ============================================================================
// ebl_pkg
// Shared types and codes for the escaped byte link endpoint.
// ============================================================================
`default_nettype none

package ebl_pkg;

    localparam int RX_BUFFER_BYTES_DEF = 32768;

    localparam logic [7:0]  ESC_BYTE  = 8'hFE;
    localparam logic [15:0] MAX_COUNT = 16'hFFFF;
    localparam logic [13:0] LIMIT_RST = 14'h3FFF;

    localparam logic [1:0] FUNC_RX    = 2'd0;
    localparam logic [1:0] FUNC_TX    = 2'd1;
    localparam logic [1:0] FUNC_GRANT = 2'd2;

    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_TX   = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_DEBT   = 2'd1;
    localparam logic [1:0] STAT_NO_CREDIT = 2'd2;

    typedef enum logic [2:0] {
        PH_DATA = 3'b001,
        PH_ESC  = 3'b010,
        PH_HIGH = 3'b100
    } ebl_phase_t;

    // results of one request, slot 0 goes out first
    typedef struct packed {
        logic [1:0]       count;
        logic [2:0][1:0]  kind;
        logic [2:0][7:0]  data;
        logic [15:0]      debt;
        logic [15:0]      credit;
        logic [1:0]       status;
    } ebl_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/ebl_core.sv
// ============================================================================
// ebl_core
// Unescape, credit/debt counters and grant encoding for one request.
// ============================================================================
`default_nettype none

module ebl_core #(
    parameter int RX_BUFFER_BYTES = ebl_pkg::RX_BUFFER_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [13:0]       cfg_data,
    input  wire logic              fire,
    input  wire logic [1:0]        func,
    input  wire logic [7:0]        byte_in,
    input  wire logic [15:0]       free_space,
    output ebl_pkg::ebl_res_t      res
);

    localparam logic [16:0] CAP = 17'(RX_BUFFER_BYTES);

    ebl_pkg::ebl_phase_t phase_reg, phase_next;
    logic [6:0]  held_reg, held_next;
    logic [15:0] debt_reg, debt_next;
    logic [15:0] credit_reg, credit_next;
    logic [13:0] limit_reg;

    logic [15:0] free_clamped;
    logic [15:0] room;
    logic [13:0] grant_n;
    logic [16:0] debt_sum;
    logic [16:0] credit_sum;

    always_comb
    begin
        free_clamped = ({1'b0, free_space} > CAP) ? CAP[15:0] : free_space;
        room         = (free_clamped > credit_reg) ? free_clamped - credit_reg : 16'd0;
        grant_n      = (room < {2'b0, limit_reg}) ? room[13:0] : limit_reg;
        debt_sum     = {1'b0, debt_reg} + {2'b0, held_reg, byte_in};
        credit_sum   = {1'b0, credit_reg} + {3'b0, grant_n};
    end

    always_comb
    begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        debt_next   = debt_reg;
        credit_next = credit_reg;
        res.count   = 2'd1;
        res.kind    = {3{ebl_pkg::KIND_NONE}};
        res.data    = '0;
        res.status  = ebl_pkg::STAT_OK;

        unique case (func)
            ebl_pkg::FUNC_RX:
            begin
                unique case (phase_reg)
                    ebl_pkg::PH_ESC:
                    begin
                        if (byte_in == ebl_pkg::ESC_BYTE)
                        begin
                            phase_next  = ebl_pkg::PH_DATA;
                            res.kind[0] = ebl_pkg::KIND_RX;
                            res.data[0] = byte_in;
                            if (credit_reg == '0)
                                res.status = ebl_pkg::STAT_NO_CREDIT;
                            else
                                credit_next = credit_reg - 16'd1;
                        end
                        else
                        begin
                            held_next  = byte_in[7:1];
                            phase_next = ebl_pkg::PH_HIGH;
                        end
                    end
                    ebl_pkg::PH_HIGH:
                    begin
                        debt_next  = debt_sum[16] ? ebl_pkg::MAX_COUNT : debt_sum[15:0];
                        phase_next = ebl_pkg::PH_DATA;
                    end
                    default:
                    begin
                        if (byte_in == ebl_pkg::ESC_BYTE)
                            phase_next = ebl_pkg::PH_ESC;
                        else
                        begin
                            phase_next  = ebl_pkg::PH_DATA;
                            res.kind[0] = ebl_pkg::KIND_RX;
                            res.data[0] = byte_in;
                            if (credit_reg == '0)
                                res.status = ebl_pkg::STAT_NO_CREDIT;
                            else
                                credit_next = credit_reg - 16'd1;
                        end
                    end
                endcase
            end
            ebl_pkg::FUNC_TX:
            begin
                if (debt_reg == '0)
                    res.status = ebl_pkg::STAT_NO_DEBT;
                else
                begin
                    debt_next   = debt_reg - 16'd1;
                    res.kind[0] = ebl_pkg::KIND_TX;
                    res.data[0] = byte_in;
                    if (byte_in == ebl_pkg::ESC_BYTE)
                    begin
                        // escape byte goes out twice
                        res.count   = 2'd2;
                        res.kind[1] = ebl_pkg::KIND_TX;
                        res.data[1] = byte_in;
                    end
                end
            end
            ebl_pkg::FUNC_GRANT:
            begin
                if (grant_n != '0)
                begin
                    res.count   = 2'd3;
                    res.kind    = {3{ebl_pkg::KIND_TX}};
                    res.data[0] = ebl_pkg::ESC_BYTE;
                    res.data[1] = {1'b0, grant_n[13:8], 1'b1};
                    res.data[2] = grant_n[7:0];
                    credit_next = credit_sum[16] ? ebl_pkg::MAX_COUNT : credit_sum[15:0];
                end
            end
            default:
            begin
                res.count = 2'd1;
            end
        endcase

        res.debt   = debt_next;
        res.credit = credit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ebl_pkg::PH_DATA;
            held_reg   <= '0;
            debt_reg   <= '0;
            credit_reg <= '0;
            limit_reg  <= ebl_pkg::LIMIT_RST;
        end
        else
        begin
            if (fire)
            begin
                phase_reg  <= phase_next;
                held_reg   <= held_next;
                debt_reg   <= debt_next;
                credit_reg <= credit_next;
            end
            if (cfg_we)
                limit_reg <= cfg_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ebl_out_queue.sv
// ============================================================================
// ebl_out_queue
// Result register: holds up to three results of one request, shifts them out.
// ============================================================================
`default_nettype none

module ebl_out_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load_valid,
    output logic                   load_ready,
    input  wire ebl_pkg::ebl_res_t res,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata,   // byte_out, debt_now, credit_now, status, pad
    output logic                   m_tlast,
    output logic [1:0]             m_tuser    // kind
);

    logic [1:0]       cnt_reg, cnt_next;
    logic [2:0][1:0]  kind_reg;
    logic [2:0][7:0]  data_reg;
    logic [15:0]      debt_reg;
    logic [15:0]      credit_reg;
    logic [1:0]       status_reg;
    logic             load;
    logic             take;

    assign m_tvalid   = (cnt_reg != 2'd0);
    assign take       = m_tvalid && m_tready;
    assign load_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign load       = load_valid && load_ready;

    assign m_tlast = (cnt_reg == 2'd1);
    assign m_tuser = kind_reg[0];
    assign m_tdata = {6'd0, status_reg, credit_reg, debt_reg, data_reg[0]};

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
            cnt_next = res.count;
        else if (take)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= res.kind;
            data_reg   <= res.data;
            debt_reg   <= res.debt;
            credit_reg <= res.credit;
            status_reg <= res.status;
        end
        else if (take)
        begin
            kind_reg <= {ebl_pkg::KIND_NONE, kind_reg[2:1]};
            data_reg <= {8'd0, data_reg[2:1]};
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/escaped_byte_link_with_credits.sv
// ============================================================================
// escaped_byte_link_with_credits
// Host-side byte link endpoint: FE escape framing plus credit flow control.
// ============================================================================
// Usage:
//   s_* takes requests: s_tuser selects the function (0 line byte received,
//   1 payload byte to send, 2 credit grant), s_tdata carries the byte and the
//   free receive space. m_* returns one to three results per request; the
//   final one has m_tlast set. m_tuser is the kind (0 payload delivered,
//   1 line byte to transmit, 2 no byte).
//   cfg_we/cfg_data write grant_limit (reset 16383) while the link is idle.
// Timing:
//   A request waits in the input register, is decoded in one pass and lands
//   in the result register. Throughput is one request per cycle for
//   single-result requests while m_tready stays high; a request with several
//   results holds the result port until all are taken (escaped send, grant).
// Reset:
//   Receive phase plain, debt and credit zero, grant_limit 16383.
// Stall:
//   A stalled m_tready holds the result; the input register still takes one
//   more request, then s_tready drops until the result port drains.
// ============================================================================
`default_nettype none

module escaped_byte_link_with_credits #(
    parameter int RX_BUFFER_BYTES = ebl_pkg::RX_BUFFER_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: grant_limit
    input  wire logic        cfg_we,
    input  wire logic [13:0] cfg_data,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // byte_in, free_space
    input  wire logic [1:0]  s_tuser,   // func
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // byte_out, debt_now, credit_now, status, pad
    output logic             m_tlast,
    output logic [1:0]       m_tuser    // kind
);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  func_reg;
    logic [7:0]  byte_reg;
    logic [15:0] free_reg;

    logic              q_ready;
    logic              move;     // request leaves input register into results
    logic              s_accept;
    ebl_pkg::ebl_res_t res;

    assign move     = in_valid_reg && q_ready;
    assign s_tready = !in_valid_reg || move;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (move)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            func_reg <= s_tuser;
            byte_reg <= s_tdata[7:0];
            free_reg <= s_tdata[23:8];
        end
    end

    // decode and state update, committed when the request moves on
    ebl_core #(
        .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .fire       (move),
        .func       (func_reg),
        .byte_in    (byte_reg),
        .free_space (free_reg),
        .res        (res)
    );

    // result register, drains one result per cycle while m_tready is high
    ebl_out_queue u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid_reg),
        .load_ready (q_ready),
        .res        (res),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// File: bench/escaped_byte_link_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_byte_link_checker
// Watches the request, result and config ports of the escaped byte link.
// It predicts every result from its own copy of the link state and
// compares accepted results in order.
// ----------------------------------------------------------------------------

module escaped_byte_link_checker
    import ebl_pkg::*;
#(
    parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [13:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          results_due
);

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  byte_out;
        logic        last;
        logic [15:0] debt;
        logic [15:0] credit;
        logic [1:0]  status;
    } link_result_t;

    link_result_t due_results[$];

    ebl_phase_t  rx_phase;
    logic [6:0]  held_high;
    logic [15:0] debt_count;
    logic [15:0] credit_count;
    logic [13:0] grant_limit;
    int          results_seen;

    initial
    begin
        fail_count  = 0;
        results_due = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // one unit of receive credit per delivered payload byte
    function automatic logic [1:0] take_credit();
        if (credit_count == 16'd0)
            return STAT_NO_CREDIT;
        credit_count--;
        return STAT_OK;
    endfunction

    task automatic predict_link_request(input logic [1:0] func, input logic [7:0] b,
                                        input logic [15:0] free_sp);
        link_result_t res[3];
        int           cnt;
        int unsigned  sum, room, n, capped;
        for (int k = 0; k < 3; k++)
        begin
            res[k].kind     = KIND_NONE;
            res[k].byte_out = 8'h00;
            res[k].status   = STAT_OK;
        end
        cnt = 1;
        case (func)
            FUNC_RX:
            begin
                if (rx_phase == PH_ESC)
                begin
                    if (b == ESC_BYTE)
                    begin
                        rx_phase        = PH_DATA;
                        res[0].kind     = KIND_RX;
                        res[0].byte_out = b;
                        res[0].status   = take_credit();
                    end
                    else
                    begin
                        held_high = b[7:1];
                        rx_phase  = PH_HIGH;
                    end
                end
                else if (rx_phase == PH_HIGH)
                begin
                    sum        = int'(debt_count) + int'({held_high, b});
                    debt_count = (sum > MAX_COUNT) ? MAX_COUNT : sum[15:0];
                    rx_phase   = PH_DATA;
                end
                else if (b == ESC_BYTE)
                begin
                    rx_phase = PH_ESC;
                end
                else
                begin
                    res[0].kind     = KIND_RX;
                    res[0].byte_out = b;
                    res[0].status   = take_credit();
                end
            end
            FUNC_TX:
            begin
                if (debt_count == 16'd0)
                begin
                    res[0].status = STAT_NO_DEBT;
                end
                else
                begin
                    debt_count--;
                    res[0].kind     = KIND_TX;
                    res[0].byte_out = b;
                    if (b == ESC_BYTE)
                    begin
                        res[1].kind     = KIND_TX;
                        res[1].byte_out = b;
                        cnt = 2;
                    end
                end
            end
            FUNC_GRANT:
            begin
                capped = (free_sp > RX_BUFFER_BYTES) ? RX_BUFFER_BYTES : free_sp;
                room   = (capped > credit_count) ? capped - credit_count : 0;
                n      = (room < grant_limit) ? room : grant_limit;
                if (n != 0)
                begin
                    res[0].kind     = KIND_TX;
                    res[0].byte_out = ESC_BYTE;
                    res[1].kind     = KIND_TX;
                    res[1].byte_out = 8'(1 | ((n >> 8) << 1));
                    res[2].kind     = KIND_TX;
                    res[2].byte_out = n[7:0];
                    sum          = int'(credit_count) + n;
                    credit_count = (sum > MAX_COUNT) ? MAX_COUNT : sum[15:0];
                    cnt = 3;
                end
            end
            default:
            begin
                // unused function code: one empty result
            end
        endcase
        for (int k = 0; k < cnt; k++)
        begin
            res[k].last   = (k == cnt - 1);
            res[k].debt   = debt_count;
            res[k].credit = credit_count;
            due_results.push_back(res[k]);
        end
    endtask

    task automatic check_link_result();
        link_result_t want;
        logic [7:0]   got_byte;
        logic [15:0]  got_debt, got_credit;
        logic [1:0]   got_status;
        got_byte   = m_tdata[7:0];
        got_debt   = m_tdata[23:8];
        got_credit = m_tdata[39:24];
        got_status = m_tdata[41:40];
        results_seen++;
        if (due_results.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with nothing due (kind %0d byte %02h)",
                                      results_seen, m_tuser, got_byte));
            return;
        end
        want = due_results.pop_front();
        if (m_tuser !== want.kind)
            report_mismatch($sformatf("result %0d kind %0d, want %0d",
                                      results_seen, m_tuser, want.kind));
        if (got_byte !== want.byte_out)
            report_mismatch($sformatf("result %0d byte %02h, want %02h",
                                      results_seen, got_byte, want.byte_out));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("result %0d last %0d, want %0d",
                                      results_seen, m_tlast, want.last));
        if (got_debt !== want.debt)
            report_mismatch($sformatf("result %0d debt %0d, want %0d",
                                      results_seen, got_debt, want.debt));
        if (got_credit !== want.credit)
            report_mismatch($sformatf("result %0d credit %0d, want %0d",
                                      results_seen, got_credit, want.credit));
        if (got_status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      results_seen, got_status, want.status));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase     = PH_DATA;
            held_high    = 7'd0;
            debt_count   = 16'd0;
            credit_count = 16'd0;
            grant_limit  = LIMIT_RST;
            due_results.delete();
        end
        else
        begin
            if (cfg_we)
                grant_limit = cfg_data;
            if (s_tvalid && s_tready)
                predict_link_request(s_tuser, s_tdata[7:0], s_tdata[23:8]);
            if (m_tvalid && m_tready)
                check_link_result();
        end
        results_due = due_results.size();
    end

endmodule

// File: bench/escaped_byte_link_with_credits_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_byte_link_with_credits_tb
// Stimulus and verdict for the escaped byte link endpoint.
// A short directed pass hits the corner cases (no credit, no debt, empty and
// clamped grants, escape pairs, debt saturation, the unused function code),
// then mostly well-formed random debt messages, payload and grants run under
// several grant limits and three idling profiles. The checker beside the
// block predicts and compares; this module only drives and decides.
// ----------------------------------------------------------------------------

module escaped_byte_link_with_credits_tb;
    import ebl_pkg::*;

    // cycles without any accepted request or result before giving up
    localparam int STALL_LIMIT = 4000;
    // settling wait after the drain before touching grant_limit
    localparam int SETTLE_CYCLES = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [13:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // byte_in, free_space
    logic [1:0]  s_tuser = '0;     // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // byte_out, debt_now, credit_now, status, pad
    logic        m_tlast;
    logic [1:0]  m_tuser;          // kind

    int fail_count;
    int results_due;

    // idling percentages, changed between phases of the run
    int send_idle_pct = 34;
    int recv_idle_pct = 81;
    int sent_requests = 0;
    int quiet_cycles  = 0;

    escaped_byte_link_with_credits u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    escaped_byte_link_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    // Result side: ready toggles at random on falling edges.
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any handshake, or reset, clears the count of quiet cycles.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one request from a falling edge and hold it until accepted.
    // Returns on the falling edge after the accepting rising edge, so a
    // following request keeps tvalid high without a glitch.
    task automatic push_request(input logic [1:0] func, input logic [7:0] b,
                                input logic [15:0] free_sp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {free_sp, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        sent_requests++;
    endtask

    // Sender holds off until every predicted result has been taken, then
    // lets the pipeline settle. Called on a falling edge.
    task automatic drain_link();
        s_tvalid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_grant_limit(input logic [13:0] value);
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_free_space();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return 16'($urandom_range(0, 300));
        else if (pick < 45)
            return 16'(RX_BUFFER_BYTES_DEF);
        else if (pick < 60)
            return 16'($urandom_range(32769, 65535));   // beyond the buffer
        else
            return 16'($urandom_range(0, 32768));
    endfunction

    // Random traffic: mostly well-formed debt messages, payload and grants,
    // with some lone escapes and the unused function code as noise.
    task automatic random_traffic(input int count);
        int         pick;
        int         stop_at;
        logic [7:0] hi;
        logic [7:0] b;
        stop_at = sent_requests + count;
        while (sent_requests < stop_at)
        begin
            pick = $urandom_range(99);
            b    = 8'($urandom);
            if (pick < 28)
            begin
                // debt message FE hi lo; small amounts keep debt off the rail
                hi = ($urandom_range(99) < 70) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                push_request(FUNC_RX, ESC_BYTE, 16'($urandom));
                push_request(FUNC_RX, hi, 16'($urandom));
                push_request(FUNC_RX, b, 16'($urandom));
            end
            else if (pick < 48)
            begin
                if ($urandom_range(99) < 20)
                begin
                    push_request(FUNC_RX, ESC_BYTE, 16'($urandom));
                    push_request(FUNC_RX, ESC_BYTE, 16'($urandom));
                end
                else
                    push_request(FUNC_RX, b, 16'($urandom));
            end
            else if (pick < 68)
                push_request(FUNC_TX, ($urandom_range(99) < 15) ? ESC_BYTE : b,
                             16'($urandom));
            else if (pick < 88)
                push_request(FUNC_GRANT, b, pick_free_space());
            else if (pick < 94)
                push_request(FUNC_RX, ESC_BYTE, 16'($urandom));   // lone escape
            else
                push_request(2'd3, b, 16'($urandom));              // unused code
        end
    endtask

    initial
    begin
        logic [13:0] limits[6];
        limits = '{14'd1, LIMIT_RST, 14'd256, 14'd0, 14'd255, 14'd1};
        limits[5] = 14'($urandom_range(1, 16383));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed: grant_limit at its reset value ----
        push_request(FUNC_RX, 8'h41, 16'h0000);        // payload with no credit
        push_request(FUNC_TX, 8'h55, 16'hFFFF);        // send with no debt
        push_request(FUNC_GRANT, 8'h00, 16'h0000);     // empty grant
        push_request(FUNC_GRANT, 8'hFF, 16'hFFFF);     // clamped, full tranche
        push_request(FUNC_GRANT, 8'h00, 16'd100);      // free below credit
        push_request(FUNC_RX, ESC_BYTE, 16'h0000);     // FE FE gives payload FE
        push_request(FUNC_RX, ESC_BYTE, 16'h0000);
        push_request(FUNC_RX, ESC_BYTE, 16'h0000);     // debt FE FF FF
        push_request(FUNC_RX, 8'hFF, 16'h0000);
        push_request(FUNC_RX, 8'hFF, 16'h0000);
        push_request(FUNC_RX, ESC_BYTE, 16'h0000);     // again, near the rail
        push_request(FUNC_RX, 8'hFF, 16'h0000);
        push_request(FUNC_RX, 8'hFF, 16'h0000);
        push_request(FUNC_RX, ESC_BYTE, 16'h0000);     // debt saturates here
        push_request(FUNC_RX, 8'h02, 16'h0000);
        push_request(FUNC_RX, 8'h05, 16'h0000);
        push_request(FUNC_TX, ESC_BYTE, 16'h0000);     // escaped send, doubled
        push_request(FUNC_TX, 8'h00, 16'h0000);
        push_request(FUNC_TX, 8'hFF, 16'h0000);
        push_request(FUNC_RX, 8'h00, 16'h0000);
        push_request(FUNC_RX, 8'hFF, 16'h0000);
        push_request(2'd3, 8'hAA, 16'h5555);           // unused function code
        push_request(2'd3, 8'h55, 16'hAAAA);
        push_request(FUNC_GRANT, 8'h00, 16'd32768);

        // ---- random phases: idling profile changes every two segments ----
        for (int seg = 0; seg < 6; seg++)
        begin
            drain_link();
            if (seg == 2)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 34;
            end
            else if (seg == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_grant_limit(limits[seg]);
            random_traffic((seg == 3) ? 30 : 70);
        end

        // ---- wind down: wait for every result, then let the link settle ----
        drain_link();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
